// ===== rtl/i2p_pkg.sv =====
package i2p_pkg;

   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNMATCHED = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic push;
      logic pop;
      logic emit;
      logic emit_top;
      logic unmatched;
      logic release_pend;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic err_any;
      logic last;
      logic is_space;
      logic is_lparen;
      logic is_rparen;
      logic is_op;
      logic top_is_lparen;
      logic top_prec_ge;
      logic emit_ok;
      logic out_free;
   } stat_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      case (c)
         CHAR_CARET: p = 2'd3;
         CHAR_STAR, CHAR_SLASH: p = 2'd2;
         CHAR_PLUS, CHAR_MINUS: p = 2'd1;
         default: p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CHAR_CARET) || (c == CHAR_STAR) || (c == CHAR_SLASH) ||
             (c == CHAR_PLUS) || (c == CHAR_MINUS);
   endfunction

endpackage

// ===== rtl/i2p_if.sv =====
interface i2p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface i2p_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_has_char;
   logic       out_last;
   logic [1:0] out_error;

   modport source (output valid, output out_char, output out_has_char,
                   output out_last, output out_error, input ready);
   modport sink   (input valid, input out_char, input out_has_char,
                   input out_last, input out_error, output ready);
endinterface

// ===== rtl/i2p_ram.sv =====
module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/i2p_dp.sv =====
module i2p_dp #(
   parameter int STACK_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  i2p_pkg::cmd_type  cmd,
   output i2p_pkg::stat_type stat,
   input  logic [7:0]        req_char,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_char,
   output logic              rsp_has_char,
   output logic              rsp_last,
   output logic [1:0]        rsp_error
);
   import i2p_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] count_dec;
   logic [1:0]    err_ff, err_in;
   logic          pend_v_ff, pend_v_in;
   logic [7:0]    pend_char_ff, pend_char_in;
   logic [1:0]    pend_err_ff, pend_err_in;
   logic          out_v_ff, out_v_in;
   logic [7:0]    out_char_ff, out_char_in;
   logic          out_has_ff, out_has_in;
   logic          out_last_ff, out_last_in;
   logic [1:0]    out_err_ff, out_err_in;

   logic          full;
   logic          out_free;
   logic [7:0]    emit_char;
   logic          wr_en;
   logic [7:0]    top_data;

   assign count_dec = count_ff - CW'(1);
   assign full      = (count_ff >= CW'(STACK_DEPTH));
   assign out_free  = !out_v_ff || rsp_ready;
   assign emit_char = cmd.emit_top ? top_data : char_ff;
   assign wr_en     = cmd.push && !full;

   // The stack top is read continuously; its data follows a count change in the next cycle.
   i2p_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (char_ff),
      .rd_addr (count_dec[AW-1:0]),
      .rd_data (top_data)
   );

   always_comb begin
      char_in      = char_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      pend_v_in    = pend_v_ff;
      pend_char_in = pend_char_ff;
      pend_err_in  = pend_err_ff;
      out_v_in     = out_v_ff;
      out_char_in  = out_char_ff;
      out_has_in   = out_has_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      if (rsp_ready) begin
         out_v_in = 1'b0;
      end

      if (cmd.load) begin
         char_in = req_char;
         last_in = req_last;
      end

      if (cmd.pop) begin
         count_in = count_dec;
      end

      if (cmd.push) begin
         if (full) begin
            if (err_ff == ERR_NONE) begin
               err_in = ERR_OVERFLOW;
            end
            count_in = '0;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end

      if (cmd.unmatched) begin
         if (err_ff == ERR_NONE) begin
            err_in = ERR_UNMATCHED;
         end
         count_in = '0;
      end

      // A new result waits in the pending slot until it is known not to be the last one.
      if (cmd.emit) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_char_in = pend_char_ff;
            out_has_in  = 1'b1;
            out_last_in = 1'b0;
            out_err_in  = pend_err_ff;
         end
         pend_v_in    = 1'b1;
         pend_char_in = emit_char;
         pend_err_in  = err_ff;
      end

      if (cmd.release_pend && pend_v_ff) begin
         out_v_in    = 1'b1;
         out_char_in = pend_char_ff;
         out_has_in  = 1'b1;
         out_last_in = 1'b0;
         out_err_in  = pend_err_ff;
         pend_v_in   = 1'b0;
      end

      if (cmd.finish) begin
         out_v_in    = 1'b1;
         out_char_in = pend_v_ff ? pend_char_ff : 8'd0;
         out_has_in  = pend_v_ff;
         out_last_in = 1'b1;
         out_err_in  = err_ff;
         pend_v_in   = 1'b0;
         count_in    = '0;
         err_in      = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         err_ff    <= ERR_NONE;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         err_ff    <= err_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      last_ff      <= last_in;
      pend_char_ff <= pend_char_in;
      pend_err_ff  <= pend_err_in;
      out_char_ff  <= out_char_in;
      out_has_ff   <= out_has_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   always_comb begin
      stat.count_zero    = (count_ff == '0);
      stat.err_any       = (err_ff != ERR_NONE);
      stat.last          = last_ff;
      stat.is_space      = (char_ff == CHAR_SPACE) || (char_ff == CHAR_TAB);
      stat.is_lparen     = (char_ff == CHAR_LPAREN);
      stat.is_rparen     = (char_ff == CHAR_RPAREN);
      stat.is_op         = is_operator(char_ff);
      stat.top_is_lparen = (top_data == CHAR_LPAREN);
      stat.top_prec_ge   = (prec_of(top_data) >= prec_of(char_ff));
      stat.emit_ok       = !pend_v_ff || out_free;
      stat.out_free      = out_free;
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_char     = out_char_ff;
   assign rsp_has_char = out_has_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_error    = out_err_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && pend_v_ff) |-> out_free)
      else $error("pending result pushed into a busy output register");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (count_ff == '0) && (err_ff == ERR_NONE) && !pend_v_ff)
      else $error("expression end left state behind");

   a_bare_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_has_ff) |-> out_last_ff)
      else $error("bare marker without last flag");

endmodule

// ===== rtl/i2p_ctrl.sv =====
module i2p_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  i2p_pkg::stat_type stat,
   output i2p_pkg::cmd_type  cmd
);
   import i2p_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_CLOSE,
      S_CLOSE_RD,
      S_OP,
      S_OP_RD,
      S_EMIT_CHAR,
      S_PUSH,
      S_END,
      S_FLUSH,
      S_FLUSH_RD,
      S_FINAL
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.err_any || stat.is_space) begin
               state_in = S_END;
            end else if (stat.is_lparen) begin
               state_in = S_PUSH;
            end else if (stat.is_rparen) begin
               state_in = S_CLOSE;
            end else if (stat.is_op) begin
               state_in = S_OP;
            end else begin
               state_in = S_EMIT_CHAR;
            end
         end
         S_CLOSE: begin
            if (stat.count_zero) begin
               cmd.unmatched = 1'b1;
               state_in      = S_END;
            end else begin
               state_in = S_CLOSE_RD;
            end
         end
         S_CLOSE_RD: begin
            if (stat.top_is_lparen) begin
               cmd.pop  = 1'b1;
               state_in = S_END;
            end else if (stat.emit_ok) begin
               cmd.pop      = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_top = 1'b1;
               state_in     = S_CLOSE;
            end
         end
         S_OP: begin
            state_in = stat.count_zero ? S_PUSH : S_OP_RD;
         end
         S_OP_RD: begin
            if (!stat.top_prec_ge) begin
               state_in = S_PUSH;
            end else if (stat.emit_ok) begin
               cmd.pop      = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_top = 1'b1;
               state_in     = S_OP;
            end
         end
         S_EMIT_CHAR: begin
            if (stat.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = S_END;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_END;
         end
         S_END: begin
            if (stat.last) begin
               state_in = (stat.err_any || stat.count_zero) ? S_FINAL : S_FLUSH;
            end else if (stat.emit_ok) begin
               cmd.release_pend = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_FLUSH: begin
            state_in = stat.count_zero ? S_FINAL : S_FLUSH_RD;
         end
         S_FLUSH_RD: begin
            if (stat.emit_ok) begin
               cmd.pop      = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_top = 1'b1;
               state_in     = S_FLUSH;
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// Channel   Dir  Beat payload                                    Accepted when
// req_bus   in   in_char[7:0], in_last                           valid && ready
// rsp_bus   out  out_char[7:0], out_has_char, out_last,          valid && ready
//                out_error[1:0]
//
// Sequencing: every operator popped off the stack, and every entry flushed at the end,
// is read through the stack's registered read port. A final character also issues the
// marked last beat, and with a non-empty stack it first sees the stack drained.
// Reset: synchronous and active high; it empties the stack and clears the error.
// Stalls: a beat waits in the output register while req_bus is taken; the sequencer
// only holds when a second result needs that register.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input logic       clock,
   input logic       reset,
   i2p_req_if.sink   req_bus,
   i2p_rsp_if.source rsp_bus
);
   import i2p_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   // The controller sequences each character; the datapath owns the stack,
   // the error state and the two result registers.
   i2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Results are held one step back in a pending slot, so that the last one of an
   // expression can still be flagged last and carry the final error code.
   i2p_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_char     (req_bus.in_char),
      .req_last     (req_bus.in_last),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_char     (rsp_bus.out_char),
      .rsp_has_char (rsp_bus.out_has_char),
      .rsp_last     (rsp_bus.out_last),
      .rsp_error    (rsp_bus.out_error)
   );

   assign req_bus.ready = req_ready;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   import i2p_pkg::*;

   // The block is built with a 32-entry operator stack, and the predictor
   // below keeps a stack of the same depth.
   localparam int STACK_DEPTH = 32;

   // Random stimulus stops once this many characters have been queued.
   localparam int RANDOM_CHARS = 350;

   // In the last characters of the run neither side inserts random idles.
   localparam int TAIL_ITEMS = 60;

   // A long receiver hold-off starts once this many characters are in.
   localparam int HOLD_OFF_START  = 150;
   localparam int HOLD_OFF_CYCLES = 300;

   // Worst beat of the block: one character, a flush of a full stack,
   // and the marked final beat. The drain wait covers it.
   localparam int DRAIN_CYCLES = 100;

   // A correct run ends well before this limit.
   localparam int CYCLE_LIMIT = 200000;

   // One character waiting to be sent. The drain flag makes the sender wait
   // until every predicted postfix beat has come back before offering it.
   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       hold_until_drained;
   } infix_char_type;

   // One predicted beat of the result channel.
   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       last;
      logic [1:0] error;
   } postfix_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2p_req_if req_bus ();
   i2p_rsp_if rsp_bus ();

   infix_to_postfix_converter #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Characters still to be sent, and postfix beats still to be received.
   infix_char_type   pending_chars[$];
   postfix_beat_type postfix_expected[$];

   // Scratch buffer that holds one expression while it is being built.
   logic [7:0] expr_buf[$];

   // Predictor state: the operator stack, its fill and the sticky error.
   logic [7:0] model_stack [0:STACK_DEPTH-1];
   int         model_depth = 0;
   logic [1:0] model_error = ERR_NONE;

   int mismatch_count   = 0;
   int chars_accepted   = 0;
   int beats_checked    = 0;
   int expressions_sent = 0;
   int overflow_ends    = 0;
   int unmatched_ends   = 0;
   int cycle_count      = 0;

   int               send_gap = 0;
   int               take_gap = 0;
   int               hold_off_left = 0;
   logic             hold_off_done = 1'b0;
   logic             tail_phase = 1'b0;
   postfix_beat_type rsp_want;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Precedence of an arithmetic operator; every other character ranks 0,
   // so a nonzero rank also identifies an operator.
   function automatic int op_rank(input logic [7:0] c);
      case (c)
         CHAR_CARET: return 3;
         CHAR_STAR, CHAR_SLASH: return 2;
         CHAR_PLUS, CHAR_MINUS: return 1;
         default: return 0;
      endcase
   endfunction

   task automatic emit_postfix(input logic [7:0] ch, input logic has);
      postfix_beat_type beat;
      beat.ch       = ch;
      beat.has_char = has;
      beat.last     = 1'b0;
      beat.error    = model_error;
      postfix_expected.push_back(beat);
   endtask

   // Only the first error of an expression is kept, but every error empties
   // the stack.
   task automatic raise_error(input logic [1:0] code);
      if (model_error == ERR_NONE) begin
         model_error = code;
      end
      model_depth = 0;
   endtask

   task automatic push_operator(input logic [7:0] c);
      if (model_depth >= STACK_DEPTH) begin
         raise_error(ERR_OVERFLOW);
      end else begin
         model_stack[model_depth] = c;
         model_depth++;
      end
   endtask

   // Works out the postfix beats caused by one accepted character and
   // appends them to postfix_expected.
   task automatic convert_char(input logic [7:0] c, input logic last);
      int               first_beat;
      logic [7:0]       top;
      bit               closing;
      postfix_beat_type final_beat;
      first_beat = postfix_expected.size();
      // Once an error has been seen, characters are ignored until the end.
      if (model_error == ERR_NONE) begin
         if (c == CHAR_SPACE || c == CHAR_TAB) begin
            // Blanks produce nothing.
         end else if (c == CHAR_LPAREN) begin
            push_operator(c);
         end else if (c == CHAR_RPAREN) begin
            closing = 1'b1;
            while (closing) begin
               if (model_depth == 0) begin
                  raise_error(ERR_UNMATCHED);
                  closing = 1'b0;
               end else begin
                  model_depth--;
                  top = model_stack[model_depth];
                  if (top == CHAR_LPAREN) begin
                     closing = 1'b0;
                  end else begin
                     emit_postfix(top, 1'b1);
                  end
               end
            end
         end else if (op_rank(c) != 0) begin
            while (model_depth > 0 && op_rank(model_stack[model_depth-1]) >= op_rank(c)) begin
               model_depth--;
               emit_postfix(model_stack[model_depth], 1'b1);
            end
            push_operator(c);
         end else begin
            emit_postfix(c, 1'b1);
         end
      end
      if (last) begin
         // A leftover open parenthesis is flushed like any operator.
         if (model_error == ERR_NONE) begin
            while (model_depth > 0) begin
               model_depth--;
               emit_postfix(model_stack[model_depth], 1'b1);
            end
         end
         model_depth = 0;
         // With nothing else to send, the end of the expression is a bare marker.
         if (postfix_expected.size() == first_beat) begin
            emit_postfix(8'h00, 1'b0);
         end
         final_beat = postfix_expected.pop_back();
         final_beat.last  = 1'b1;
         final_beat.error = model_error;
         postfix_expected.push_back(final_beat);
         model_error = ERR_NONE;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------

   function automatic logic [7:0] symbol_at(input int idx);
      case (idx)
         0: return CHAR_CARET;
         1: return CHAR_STAR;
         2: return CHAR_SLASH;
         3: return CHAR_PLUS;
         4: return CHAR_MINUS;
         5: return CHAR_LPAREN;
         6: return CHAR_RPAREN;
         7: return CHAR_SPACE;
         default: return CHAR_TAB;
      endcase
   endfunction

   // Moves the expression in expr_buf to the send queue, marking its final
   // character. With hold set, the sender drains the block before starting it.
   task automatic commit_expression(input bit hold);
      infix_char_type item;
      for (int i = 0; i < expr_buf.size(); i++) begin
         item.ch                 = expr_buf[i];
         item.last               = (i == expr_buf.size() - 1);
         item.hold_until_drained = hold && (i == 0);
         pending_chars.push_back(item);
      end
      expr_buf.delete();
      expressions_sent++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         expr_buf.push_back(s[i]);
      end
      commit_expression(1'b0);
   endtask

   // Any byte that the block passes straight through.
   task automatic add_operand();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (op_rank(c) != 0 || c == CHAR_LPAREN || c == CHAR_RPAREN ||
                 c == CHAR_SPACE || c == CHAR_TAB);
      expr_buf.push_back(c);
   endtask

   task automatic maybe_blank();
      if ($urandom_range(0, 5) == 0) begin
         expr_buf.push_back(symbol_at($urandom_range(7, 8)));
      end
   endtask

   // A well-formed expression with random operands, operators, blanks and
   // nesting. When broken, a stray parenthesis is dropped in somewhere.
   task automatic build_well_formed(input int terms, input bit broken);
      int open;
      open = 0;
      for (int k = 0; k < terms; k++) begin
         while (open < 6 && $urandom_range(0, 3) == 0) begin
            expr_buf.push_back(CHAR_LPAREN);
            open++;
         end
         maybe_blank();
         add_operand();
         while (open > 0 && $urandom_range(0, 2) == 0) begin
            expr_buf.push_back(CHAR_RPAREN);
            open--;
         end
         if (k != terms - 1) begin
            maybe_blank();
            expr_buf.push_back(symbol_at($urandom_range(0, 4)));
         end
      end
      while (open > 0) begin
         expr_buf.push_back(CHAR_RPAREN);
         open--;
      end
      if (broken) begin
         expr_buf.insert($urandom_range(0, expr_buf.size()), symbol_at($urandom_range(5, 6)));
      end
   endtask

   // A run of open parentheses around the stack depth, which may stay below
   // the stack depth, fill the stack exactly or overflow it.
   task automatic build_deep(input int opens);
      for (int k = 0; k < opens; k++) begin
         expr_buf.push_back(CHAR_LPAREN);
      end
      add_operand();
      if ($urandom_range(0, 1) == 0) begin
         expr_buf.push_back(symbol_at($urandom_range(0, 4)));
         add_operand();
      end
   endtask

   // Random bytes with plenty of operators, parentheses and blanks.
   task automatic build_noise(input int length);
      for (int k = 0; k < length; k++) begin
         if ($urandom_range(0, 1) == 0) begin
            expr_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            expr_buf.push_back(symbol_at($urandom_range(0, 8)));
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      end
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Driver: offers the head of pending_chars, with random idle bursts.
   // A beat that is being offered is held until it is taken.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.in_char <= 8'h00;
         req_bus.in_last <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            convert_char(req_bus.in_char, req_bus.in_last);
            pending_chars.delete(0);
            chars_accepted++;
         end
         tail_phase <= (pending_chars.size() <= TAIL_ITEMS);
         if (req_bus.valid && !req_bus.ready) begin
            // The block is stalling; keep the same beat on the bus.
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_chars.size() == 0 ||
                      (pending_chars[0].hold_until_drained && postfix_expected.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else if (pending_chars.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 6) - 1;
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid   <= 1'b1;
            req_bus.in_char <= pending_chars[0].ch;
            req_bus.in_last <= pending_chars[0].last;
         end
      end
   end

   // One long receiver hold-off in the middle of the run, so that the block
   // backs up and stalls its input while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         hold_off_left <= 0;
         hold_off_done <= 1'b0;
      end else if (!hold_off_done && chars_accepted >= HOLD_OFF_START) begin
         hold_off_left <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each accepted postfix beat against the oldest
   // prediction, field by field, and drives ready with random stalls.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (postfix_expected.size() == 0) begin
               report_mismatch($sformatf("unpredicted beat char=%h has=%b last=%b err=%0d",
                                         rsp_bus.out_char, rsp_bus.out_has_char,
                                         rsp_bus.out_last, rsp_bus.out_error));
            end else begin
               rsp_want = postfix_expected.pop_front();
               if (rsp_bus.out_char !== rsp_want.ch) begin
                  report_mismatch($sformatf("out_char %h, predicted %h",
                                            rsp_bus.out_char, rsp_want.ch));
               end
               if (rsp_bus.out_has_char !== rsp_want.has_char) begin
                  report_mismatch($sformatf("out_has_char %b, predicted %b",
                                            rsp_bus.out_has_char, rsp_want.has_char));
               end
               if (rsp_bus.out_last !== rsp_want.last) begin
                  report_mismatch($sformatf("out_last %b, predicted %b",
                                            rsp_bus.out_last, rsp_want.last));
               end
               if (rsp_bus.out_error !== rsp_want.error) begin
                  report_mismatch($sformatf("out_error %0d, predicted %0d",
                                            rsp_bus.out_error, rsp_want.error));
               end
               beats_checked++;
               if (rsp_want.last && rsp_want.error == ERR_OVERFLOW) begin
                  overflow_ends++;
               end
               if (rsp_want.last && rsp_want.error == ERR_UNMATCHED) begin
                  unmatched_ends++;
               end
            end
         end
         if (hold_off_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            take_gap = $urandom_range(1, 6) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still predicted",
                  cycle_count, postfix_expected.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int random_chars;
      int expr_index;
      int kind;
      bit hold;

      req_bus.valid   = 1'b0;
      req_bus.in_char = 8'h00;
      req_bus.in_last = 1'b0;
      rsp_bus.ready   = 1'b0;

      // Directed expressions: precedence, every operator, blanks, a lone
      // blank as a bare end marker, unmatched close and open parentheses,
      // characters ignored after an error, and the extreme byte values.
      queue_text("a+b*c");
      queue_text("(x^y)-\tz");
      queue_text("8/4 ");
      queue_text(" ");
      queue_text(")");
      queue_text("a)+b");
      queue_text("((a");
      expr_buf.push_back(8'h00);
      expr_buf.push_back(8'hFF);
      commit_expression(1'b0);

      // Random expressions. The first fills the stack exactly so that the
      // final flush gives the longest burst of beats; the second overflows.
      // Most of the rest are well-formed with random content.
      random_chars = 0;
      expr_index   = 0;
      while (random_chars < RANDOM_CHARS) begin
         kind = $urandom_range(0, 9);
         if (expr_index == 0) begin
            for (int k = 0; k < STACK_DEPTH; k++) begin
               expr_buf.push_back(CHAR_LPAREN);
            end
            add_operand();
         end else if (expr_index == 1) begin
            build_deep(STACK_DEPTH + 2);
         end else if (kind < 7) begin
            build_well_formed($urandom_range(1, 8), 1'b0);
         end else if (kind == 7) begin
            build_well_formed($urandom_range(1, 6), 1'b1);
         end else if (kind == 8) begin
            build_deep($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 3));
         end else begin
            build_noise($urandom_range(1, 12));
         end
         hold = (expr_index == 12) || ($urandom_range(0, 19) == 0);
         random_chars += expr_buf.size();
         commit_expression(hold);
         expr_index++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || postfix_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d expressions, %0d characters; checked %0d postfix beats.",
               expressions_sent, chars_accepted, beats_checked);
      $display("Expressions ending in overflow: %0d, in an unmatched close paren: %0d.",
               overflow_ends, unmatched_ends);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
